// ===== sv/i2cdws_pkg.sv =====
package i2cdws_pkg;

	// Control byte that follows the address byte
	localparam logic [7:0] CTRL_COMMAND = 8'h00;
	localparam logic [7:0] CTRL_DATA    = 8'h40;

	localparam int ADDR_W     = 7;
	localparam int BYTE_W     = 8;
	localparam int FRAME_BYTES = 3;
	localparam int SHIFT_W    = FRAME_BYTES * BYTE_W;

	// Half periods per byte: two per bit, then two for the ACK clock
	localparam int BIT_PAIRS  = 2 * BYTE_W;
	localparam int BYTE_PAIRS = BIT_PAIRS + 2;
	localparam int POS_W      = $clog2(BYTE_PAIRS);
	localparam int BYTE_CNT_W = $clog2(FRAME_BYTES);

	localparam logic [ADDR_W-1:0] ADDR_RESET = 7'd60;

	typedef struct packed {
		logic             opcode;
		logic [BYTE_W-1:0] payload;
	} in_item_t;

	typedef struct packed {
		logic clock_level;
		logic data_level;
		logic last;
	} out_item_t;

	// Sequencer to shift register
	typedef struct packed {
		logic load;
		logic shift;
	} shift_ctrl_t;

endpackage

// ===== sv/i2c_display_write_serializer.sv =====
// The start's first half period is registered once the sequencer has entered the start.
// A write is a frame of 58 half periods, one per cycle while the output does not stall;
// the sequencer's pair counter and the 24-bit shift register step through the frame.
// A new write may transfer in the cycle the stop's final half period is issued.
// Reset (arst_n low, asynchronous): sequencer idle, output empty, address 60.
module i2c_display_write_serializer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [i2cdws_pkg::ADDR_W-1:0]     cfg_wr_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  i2cdws_pkg::in_item_t              in_item,
	output logic                              out_valid,
	input  logic                              out_stall,
	output i2cdws_pkg::out_item_t             out_item
);
	import i2cdws_pkg::*;

	logic [ADDR_W-1:0] addr_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic              ready;
	logic              accept;
	logic              out_free;
	logic              load_en;
	logic              msb;
	out_item_t         pair;
	shift_ctrl_t       ctrl;

	// Device address register, written only while no frame is in flight (user's job)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= ADDR_RESET;
		end else if (cfg_wr_en) begin
			addr_q <= cfg_wr_data;
		end
	end

	assign in_stall = !ready;
	assign accept   = in_valid && ready;

	// Output register is free when empty or when its transfer completes now
	assign out_free = !out_valid_q || !out_stall;

	i2cdws_shifter u_shifter (
		.clk            (clk),
		.ctrl           (ctrl),
		.device_address (addr_q),
		.item           (in_item),
		.msb            (msb)
	);

	i2cdws_sequencer u_sequencer (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.out_free (out_free),
		.msb      (msb),
		.ready    (ready),
		.load_en  (load_en),
		.pair     (pair),
		.ctrl     (ctrl)
	);

	// Hold the half period until the receiver takes it; drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_en) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			out_q <= pair;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// ===== sv/i2cdws_shifter.sv =====
module i2cdws_shifter (
	input  logic                              clk,
	input  i2cdws_pkg::shift_ctrl_t           ctrl,
	input  logic [i2cdws_pkg::ADDR_W-1:0]     device_address,
	input  i2cdws_pkg::in_item_t              item,
	output logic                              msb
);
	import i2cdws_pkg::*;

	logic [SHIFT_W-1:0] sr_q;
	logic [BYTE_W-1:0]  control;

	assign control = item.opcode ? CTRL_DATA : CTRL_COMMAND;

	// Address byte first, write bit clear, then control, then payload
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			sr_q <= {device_address, 1'b0, control, item.payload};
		end else if (ctrl.shift) begin
			sr_q <= {sr_q[SHIFT_W-2:0], 1'b0};
		end
	end

	assign msb = sr_q[SHIFT_W-1];

endmodule

// ===== sv/i2cdws_sequencer.sv =====
module i2cdws_sequencer (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  logic                    out_free,
	input  logic                    msb,
	output logic                    ready,
	output logic                    load_en,
	output i2cdws_pkg::out_item_t   pair,
	output i2cdws_pkg::shift_ctrl_t ctrl
);
	import i2cdws_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_START0 = 3'd1;
	localparam logic [2:0] ST_START1 = 3'd2;
	localparam logic [2:0] ST_BYTES  = 3'd3;
	localparam logic [2:0] ST_STOP0  = 3'd4;
	localparam logic [2:0] ST_STOP1  = 3'd5;

	localparam logic [POS_W-1:0]      POS_ACK_HI = POS_W'(BYTE_PAIRS - 1);
	localparam logic [POS_W-1:0]      POS_BITS   = POS_W'(BIT_PAIRS);
	localparam logic [BYTE_CNT_W-1:0] BYTE_LAST  = BYTE_CNT_W'(FRAME_BYTES - 1);

	logic [2:0]            state_q;
	logic [POS_W-1:0]      pos_q;
	logic [BYTE_CNT_W-1:0] byte_q;
	logic                  in_bits;

	assign load_en = (state_q != ST_IDLE) && out_free;
	assign ready   = (state_q == ST_IDLE) || ((state_q == ST_STOP1) && load_en);
	assign in_bits = pos_q < POS_BITS;

	always_comb begin
		pair = '0;
		unique case (state_q)
			ST_START0: pair = '{clock_level: 1'b1, data_level: 1'b1, last: 1'b0};
			ST_START1: pair = '{clock_level: 1'b1, data_level: 1'b0, last: 1'b0};
			ST_BYTES:  pair = '{clock_level: pos_q[0], data_level: in_bits ? msb : 1'b1,
			                    last: 1'b0};
			ST_STOP0:  pair = '{clock_level: 1'b1, data_level: 1'b0, last: 1'b0};
			ST_STOP1:  pair = '{clock_level: 1'b1, data_level: 1'b1, last: 1'b1};
			default:   pair = '0;
		endcase
	end

	// Advance the bit after its high half period
	assign ctrl.load  = accept;
	assign ctrl.shift = load_en && (state_q == ST_BYTES) && in_bits && pos_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
			byte_q  <= '0;
		end else if (accept) begin
			state_q <= ST_START0;
		end else if (load_en) begin
			unique case (state_q)
				ST_START0: state_q <= ST_START1;
				ST_START1: begin
					state_q <= ST_BYTES;
					pos_q   <= '0;
					byte_q  <= '0;
				end
				ST_BYTES: begin
					if (pos_q == POS_ACK_HI) begin
						pos_q <= '0;
						if (byte_q == BYTE_LAST) begin
							state_q <= ST_STOP0;
						end else begin
							byte_q <= byte_q + 1'b1;
						end
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				ST_STOP0: state_q <= ST_STOP1;
				ST_STOP1: state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/i2cdws_checker.sv =====
module i2cdws_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input i2cdws_pkg::out_item_t         out_item
);
	import i2cdws_pkg::*;

	// A stalled half period holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled output changed");

	// An accepted write blocks further input while its frame runs
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken twice in a row");

	// With the output empty, the frame opens with the start's idle pair once the
	// sequencer has stepped into the start
	a_start_first: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> ##1
		out_valid && out_item.clock_level && out_item.data_level && !out_item.last)
		else $error("frame did not open with start");

	// The flagged pair is the stop's released bus
	a_last_is_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.last |-> out_item.clock_level && out_item.data_level)
		else $error("last pair is not the stop");

endmodule

bind i2c_display_write_serializer i2cdws_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);

// ===== sim/tb_i2c_display_write_serializer.sv =====
`timescale 1ns / 1ps

module tb_i2c_display_write_serializer;

	import i2cdws_pkg::*;

	// Opcodes of one display write
	localparam logic OP_COMMAND = 1'b0;
	localparam logic OP_DATA    = 1'b1;

	// Address the block comes out of reset with
	localparam logic [ADDR_W-1:0] ADDR_AFTER_RESET = 7'd60;

	// Hang bound: 122 writes of 58 half periods each, any half period open to a receiver
	// stall, plus gaps between writes.
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int RANDOM_PHASES = 4;
	localparam int PHASE_WRITES  = 26;
	localparam int MAX_REPORTS   = 10;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [ADDR_W-1:0] cfg_wr_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	in_item_t          in_item = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	out_item_t         out_item;

	// Writes waiting for the driver, and the pin levels still owed by the block
	in_item_t          pending_writes[$];
	out_item_t         expected_levels[$];

	// Testbench copy of the address register
	logic [ADDR_W-1:0] dev_addr_model = ADDR_AFTER_RESET;

	// Transfer flags, captured at the rising edge for the falling-edge drivers
	logic              in_taken = 1'b0;
	logic              out_taken = 1'b0;

	// Set to run a phase with no idling on either side
	logic              calm = 1'b0;

	int                send_gap = 0;
	int                stall_left = 0;
	int                rx_wait;
	logic              tx_busy;

	int                cycle_count = 0;
	int                writes_taken = 0;
	int                levels_checked = 0;
	int                addr_writes = 0;
	int                mismatches = 0;
	int                failures = 0;

	i2c_display_write_serializer i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_item     (in_item),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_item    (out_item)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Append one expected half period
	function automatic void push_level(input logic scl, input logic sda, input logic fin);
		expected_levels.push_back(out_item_t'{clock_level: scl, data_level: sda, last: fin});
	endfunction

	// Build the whole frame for one write: start, address, control, payload, stop
	function automatic void predict_frame(input in_item_t w);
		logic [SHIFT_W-1:0] frame_bytes;
		frame_bytes = {dev_addr_model, 1'b0, (w.opcode ? CTRL_DATA : CTRL_COMMAND), w.payload};
		// start: SDA falls while SCL is high
		push_level(1'b1, 1'b1, 1'b0);
		push_level(1'b1, 1'b0, 1'b0);
		for (int i = SHIFT_W - 1; i >= 0; i--) begin
			push_level(1'b0, frame_bytes[i], 1'b0);
			push_level(1'b1, frame_bytes[i], 1'b0);
			// ACK clock after each byte, SDA released
			if (i % BYTE_W == 0) begin
				push_level(1'b0, 1'b1, 1'b0);
				push_level(1'b1, 1'b1, 1'b0);
			end
		end
		// stop: SDA rises while SCL is high, and that pair closes the frame
		push_level(1'b1, 1'b0, 1'b0);
		push_level(1'b1, 1'b1, 1'b1);
	endfunction

	function automatic void queue_write(input logic op, input logic [BYTE_W-1:0] b);
		pending_writes.push_back(in_item_t'{opcode: op, payload: b});
	endfunction

	// Write the address register; only ever called with nothing in flight
	task automatic write_address(input logic [ADDR_W-1:0] a);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= a;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		dev_addr_model = a;
		addr_writes++;
	endtask

	// Hold the sender until every write is out and every half period has come back,
	// then let the block settle
	task automatic drain_frames();
		while (pending_writes.size() != 0 || in_valid || expected_levels.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Driver: hold the payload while stalled, advance after a transfer,
	// and wait the drawn gap before offering the next write
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item  <= '0;
			send_gap <= 0;
		end else begin
			tx_busy = in_valid && !in_taken;
			if (!tx_busy) begin
				if (send_gap > 0) begin
					in_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (pending_writes.size() != 0) begin
					in_item  <= pending_writes.pop_front();
					in_valid <= 1'b1;
					send_gap <= calm ? 0 : $urandom_range(0, 13);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: after each transfer draw how long to stall before the next one.
	// Most draws are zero so the frames keep moving; the rest span the full range.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_taken)
				rx_wait = (calm || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(0, 13);
			else
				rx_wait = stall_left;
			if (rx_wait > 0) begin
				out_stall  <= 1'b1;
				stall_left <= rx_wait - 1;
			end else begin
				out_stall  <= 1'b0;
				stall_left <= 0;
			end
		end
	end

	// Monitor: check each half period against the oldest expectation, then
	// predict the frame of any write that transferred at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			out_taken <= out_valid && !out_stall;
			in_taken  <= in_valid && !in_stall;
			if (out_valid && !out_stall) begin
				if (expected_levels.size() == 0) begin
					failures++;
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected half period: scl %0b sda %0b last %0b",
							out_item.clock_level, out_item.data_level, out_item.last);
				end else begin
					if (out_item.clock_level !== expected_levels[0].clock_level ||
					    out_item.data_level  !== expected_levels[0].data_level ||
					    out_item.last        !== expected_levels[0].last) begin
						failures++;
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display({"mismatch at half period %0d: ",
								"expected scl %0b sda %0b last %0b, ",
								"got scl %0b sda %0b last %0b"},
								levels_checked,
								expected_levels[0].clock_level, expected_levels[0].data_level,
								expected_levels[0].last,
								out_item.clock_level, out_item.data_level, out_item.last);
					end
					void'(expected_levels.pop_front());
					levels_checked++;
				end
			end
			if (in_valid && !in_stall) begin
				predict_frame(in_item);
				writes_taken++;
			end
		end
	end

	// Give up on a hang
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d half periods still owed",
				cycle_count, expected_levels.size());
			$display("tb_i2c_display_write_serializer NOT OK");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset address: both opcodes against payload extremes and alternating bits
		@(posedge clk);
		for (int op = 0; op < 2; op++) begin
			queue_write(op[0], 8'h00);
			queue_write(op[0], 8'hFF);
			queue_write(op[0], 8'h80);
			queue_write(op[0], 8'h01);
			queue_write(op[0], 8'hA5);
			queue_write(op[0], 8'h5A);
		end
		drain_frames();

		// Lowest address
		write_address(7'h00);
		@(posedge clk);
		queue_write(OP_COMMAND, 8'hFF);
		queue_write(OP_DATA, 8'h00);
		queue_write(OP_DATA, 8'hFF);
		drain_frames();

		// Highest address
		write_address(7'h7F);
		@(posedge clk);
		queue_write(OP_COMMAND, 8'h00);
		queue_write(OP_DATA, 8'hFF);
		queue_write(OP_COMMAND, 8'hC3);
		drain_frames();

		// Random writes under random addresses; one phase runs with no idling.
		// Each phase boundary pauses the sender until every frame has come back.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_address(ADDR_W'($urandom_range(0, 127)));
			calm = (p == 1);
			@(posedge clk);
			repeat (PHASE_WRITES)
				queue_write(1'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)));
			drain_frames();
		end

		// Nothing is owed now; give the block time to show any stray half period
		calm = 1'b0;
		repeat (8) @(negedge clk);
		if (expected_levels.size() != 0)
			failures++;

		$display("%0d display writes framed under %0d address settings (extremes included)",
			writes_taken, addr_writes + 1);
		$display("%0d half periods checked, %0d mismatches", levels_checked, mismatches);
		if (failures == 0)
			$display("tb_i2c_display_write_serializer OK");
		else
			$display("tb_i2c_display_write_serializer NOT OK");
		$finish;
	end

endmodule
